// ===== src/pfr_pkg.sv =====
// Package for the page frame replacement block.
// Holds sizes, function and status codes, controller states and command types.
package pfr_pkg;

  localparam int FrameCount = 64;
  localparam int FrameW     = 6;
  localparam int CountW     = 7;
  localparam int SweepW     = 8;  // covers 3*FrameCount+1 visits

  typedef enum logic [1:0] {
    FUNC_REQUEST   = 2'd0,
    FUNC_MAP       = 2'd1,
    FUNC_REFERENCE = 2'd2,
    FUNC_RELEASE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_VICTIM = 2'd1,
    ST_NONE   = 2'd2,
    ST_ACK    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIFO_RD,
    S_FIFO_CHK,
    S_CLOCK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;       // capture input transaction
    logic simple;     // apply map/reference/release, set ack or free result
    logic fifo_rd;    // read ring entry at head
    logic fifo_pop;   // consume head entry
    logic fifo_take;  // grant checked entry as victim
    logic clk_start;  // reset sweep counter
    logic clk_step;   // visit one frame of the sweep
    logic set_none;   // result: no frame
  } cmd_t;

  typedef struct packed {
    logic is_request;
    logic any_free;
    logic ring_empty;
    logic entry_ok;
    logic clk_found;
    logic clk_exhausted;
    logic any_page;
  } sts_t;

endpackage

// ===== src/pfr_datapath.sv =====
// Datapath of the page frame replacement block: frame bit vectors, arrival
// ring memory, clock hand and result register. Uses pfr_pkg.
module pfr_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 func_i,
  input  logic [pfr_pkg::FrameW-1:0] frame_i,
  input  logic                       holds_page_i,
  input  logic                       is_write_i,
  input  pfr_pkg::cmd_t              cmd_i,
  output pfr_pkg::sts_t              sts_o,
  output logic [1:0]                 status_o,
  output logic [pfr_pkg::FrameW-1:0] granted_frame_o,
  output logic                       writeback_o
);

  localparam int N = pfr_pkg::FrameCount;
  localparam int W = pfr_pkg::FrameW;

  logic [N-1:0] mapped_q, type_q, acc_q, dirty_q;
  logic [W-1:0] ring_mem [N];
  logic [W-1:0] ring_rd_q;
  logic [W-1:0] head_q, hand_q;
  logic [pfr_pkg::CountW-1:0] count_q;
  logic [pfr_pkg::SweepW-1:0] sweep_q;
  logic [1:0]   func_q;
  logic [W-1:0] frame_q;
  logic         holds_q, wr_q;

  logic [N-1:0] page_vec;
  logic         any_free;
  logic [W-1:0] free_idx;
  logic         ring_wr;
  logic [W-1:0] ring_wr_addr;

  assign page_vec = mapped_q & type_q;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!mapped_q[i]) begin
        any_free = 1'b1;
        free_idx = W'(i);
      end
    end
  end

  assign ring_wr      = cmd_i.simple && (func_q == pfr_pkg::FUNC_MAP) && holds_q &&
                        (count_q < pfr_pkg::CountW'(N));
  assign ring_wr_addr = head_q + count_q[W-1:0];

  always_ff @(posedge clk_i) begin
    if (ring_wr) begin
      ring_mem[ring_wr_addr] <= frame_q;
    end
    if (cmd_i.fifo_rd) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  assign sts_o.is_request    = (func_q == pfr_pkg::FUNC_REQUEST);
  assign sts_o.any_free      = any_free;
  assign sts_o.ring_empty    = (count_q == '0);
  assign sts_o.entry_ok      = page_vec[ring_rd_q];
  assign sts_o.clk_found     = page_vec[hand_q] && !acc_q[hand_q] && !dirty_q[hand_q];
  assign sts_o.clk_exhausted = (sweep_q > pfr_pkg::SweepW'(3 * N));
  assign sts_o.any_page      = |page_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q <= '0;
      type_q   <= '0;
      acc_q    <= '0;
      dirty_q  <= '0;
      head_q   <= '0;
      count_q  <= '0;
      hand_q   <= '0;
      sweep_q  <= '0;
      func_q   <= '0;
      frame_q  <= '0;
      holds_q  <= 1'b0;
      wr_q     <= 1'b0;
      status_o <= pfr_pkg::ST_ACK;
      granted_frame_o <= '0;
      writeback_o     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        func_q  <= func_i;
        frame_q <= frame_i;
        holds_q <= holds_page_i;
        wr_q    <= is_write_i;
      end
      if (cmd_i.simple) begin
        writeback_o <= 1'b0;
        if (func_q == pfr_pkg::FUNC_REQUEST) begin
          status_o        <= pfr_pkg::ST_FREE;
          granted_frame_o <= free_idx;
        end else begin
          status_o        <= pfr_pkg::ST_ACK;
          granted_frame_o <= '0;
        end
        case (func_q)
          pfr_pkg::FUNC_REQUEST: ;
          pfr_pkg::FUNC_MAP: begin
            mapped_q[frame_q] <= 1'b1;
            type_q[frame_q]   <= holds_q;
            acc_q[frame_q]    <= 1'b0;
            dirty_q[frame_q]  <= 1'b0;
            if (ring_wr) count_q <= count_q + 1'b1;
          end
          pfr_pkg::FUNC_REFERENCE: begin
            if (mapped_q[frame_q]) begin
              acc_q[frame_q] <= 1'b1;
              if (wr_q) dirty_q[frame_q] <= 1'b1;
            end
          end
          default: begin
            mapped_q[frame_q] <= 1'b0;
            type_q[frame_q]   <= 1'b0;
            acc_q[frame_q]    <= 1'b0;
            dirty_q[frame_q]  <= 1'b0;
          end
        endcase
      end
      if (cmd_i.fifo_pop) begin
        head_q  <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.fifo_take) begin
        status_o             <= pfr_pkg::ST_VICTIM;
        granted_frame_o      <= ring_rd_q;
        writeback_o          <= dirty_q[ring_rd_q];
        acc_q[ring_rd_q]     <= 1'b0;
        dirty_q[ring_rd_q]   <= 1'b0;
      end
      if (cmd_i.clk_start) sweep_q <= '0;
      if (cmd_i.clk_step) begin
        sweep_q <= sweep_q + 1'b1;
        hand_q  <= hand_q + 1'b1;
        if (page_vec[hand_q]) begin
          if (dirty_q[hand_q]) begin
            dirty_q[hand_q] <= 1'b0;
          end else if (acc_q[hand_q]) begin
            acc_q[hand_q] <= 1'b0;
          end else begin
            status_o        <= pfr_pkg::ST_VICTIM;
            granted_frame_o <= hand_q;
            writeback_o     <= 1'b0;
          end
        end
      end
      if (cmd_i.set_none) begin
        status_o        <= pfr_pkg::ST_NONE;
        granted_frame_o <= '0;
        writeback_o     <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pfr_ctrl.sv =====
// Controller state machine of the page frame replacement block.
// Sequences transactions through pfr_datapath. Uses pfr_pkg.
module pfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          policy_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  pfr_pkg::sts_t sts_i,
  output pfr_pkg::cmd_t cmd_o
);

  pfr_pkg::state_e state_q, state_d;
  logic busy_q, busy_d;   // a captured transaction is in work
  logic ovld_q, ovld_d;

  logic can_fin;
  assign can_fin = !ovld_q || !out_stall_i;
  assign in_stall_o  = busy_q;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    ovld_d  = ovld_q && out_stall_i;
    case (state_q)
      pfr_pkg::S_IDLE: begin
        if (busy_q && can_fin) begin
          if (!sts_i.is_request || sts_i.any_free) begin
            ovld_d = 1'b1; busy_d = 1'b0;
          end else if (policy_i) begin
            if (sts_i.any_page) state_d = pfr_pkg::S_CLOCK;
            else begin ovld_d = 1'b1; busy_d = 1'b0; end
          end else if (sts_i.ring_empty) begin
            ovld_d = 1'b1; busy_d = 1'b0;
          end else state_d = pfr_pkg::S_FIFO_CHK;
        end else if (!busy_q && in_valid_i) begin
          busy_d = 1'b1;
        end
      end
      pfr_pkg::S_FIFO_CHK: begin
        if (sts_i.entry_ok) begin
          ovld_d = 1'b1; busy_d = 1'b0; state_d = pfr_pkg::S_IDLE;
        end else if (sts_i.ring_empty) begin
          ovld_d = 1'b1; busy_d = 1'b0; state_d = pfr_pkg::S_IDLE;
        end else state_d = pfr_pkg::S_FIFO_RD;
      end
      pfr_pkg::S_FIFO_RD: state_d = pfr_pkg::S_FIFO_CHK;
      pfr_pkg::S_CLOCK: begin
        if (sts_i.clk_found || sts_i.clk_exhausted) begin
          ovld_d = 1'b1; busy_d = 1'b0; state_d = pfr_pkg::S_IDLE;
        end
      end
      default: state_d = pfr_pkg::S_IDLE;
    endcase
  end

  // The ring read is registered: reading in IDLE and popping each visit keeps
  // ring_rd_q holding the entry just before the head pointer.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      pfr_pkg::S_IDLE: begin
        cmd_o.load = !busy_q && in_valid_i;
        if (busy_q && can_fin) begin
          if (!sts_i.is_request || sts_i.any_free) cmd_o.simple = 1'b1;
          else if (policy_i) begin
            if (sts_i.any_page) cmd_o.clk_start = 1'b1;
            else cmd_o.set_none = 1'b1;
          end else if (sts_i.ring_empty) cmd_o.set_none = 1'b1;
          else begin cmd_o.fifo_rd = 1'b1; cmd_o.fifo_pop = 1'b1; end
        end
      end
      pfr_pkg::S_FIFO_CHK: begin
        if (sts_i.entry_ok) cmd_o.fifo_take = 1'b1;
        else if (sts_i.ring_empty) cmd_o.set_none = 1'b1;
        else begin cmd_o.fifo_rd = 1'b1; cmd_o.fifo_pop = 1'b1; end
      end
      pfr_pkg::S_CLOCK: begin
        if (sts_i.clk_exhausted) cmd_o.set_none = 1'b1;
        else cmd_o.clk_step = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfr_pkg::S_IDLE;
      busy_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ===== src/page_frame_replacement.sv =====
// Top level of the page frame replacement block.
// Instantiates pfr_ctrl and pfr_datapath; uses pfr_pkg.
//
// One transaction at a time. Map, reference, release and a request that
// finds an unmapped frame are captured, then applied with the result
// registered. A first-in first-out victim reads and pops ring entries
// through the registered read port of the arrival ring, checking each
// entry after its read. A clock victim starts the sweep, then visits one
// frame per cycle, at most 3*64+1 visits. The result waits in an output
// register; the next transaction is taken once the result register can be
// freed.
module page_frame_replacement (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       policy_we_i,
  input  logic       policy_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [5:0] frame_i,
  input  logic       holds_page_i,
  input  logic       is_write_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [5:0] granted_frame_o,
  output logic       writeback_o
);

  logic policy_q;
  pfr_pkg::cmd_t cmd;
  pfr_pkg::sts_t sts;

  // Hold the policy register; the user must write it only while idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= 1'b0;
    else if (policy_we_i) policy_q <= policy_i;
  end

  pfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .policy_i(policy_q),
    .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pfr_datapath u_dp (
    .clk_i, .rst_ni,
    .func_i, .frame_i, .holds_page_i, .is_write_i,
    .cmd_i(cmd), .sts_o(sts),
    .status_o, .granted_frame_o, .writeback_o
  );

endmodule

// ===== src/pfr_checker.sv =====
// Port-level checker for page_frame_replacement, with its bind statement.
// Uses pfr_pkg status codes.
module pfr_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [5:0] granted_frame_o,
  input logic       writeback_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  a_wb_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_o |-> status_o == pfr_pkg::ST_VICTIM)
    else $error("writeback without victim");

  a_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pfr_pkg::ST_ACK || status_o == pfr_pkg::ST_NONE)
    |-> granted_frame_o == '0)
    else $error("frame given on ack or no-frame");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

endmodule

bind page_frame_replacement pfr_assert u_pfr_assert (.*);
